// ----- design/mti_pkg.sv -----
// Shared constants and the control type for the masked trilinear interpolator.
// No dependencies; compiled first.
package mti_pkg;

    // Corners of one cell, index = i*4 + j*2 + k
    localparam int NUM_CORNERS = 8;
    // Products that pair the x and y factors
    localparam int NUM_XY = 4;
    // Axes of the cell position
    localparam int NUM_AXES = 3;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic                   valid;
        logic [NUM_CORNERS-1:0] mask;
    } mti_ctl_t;

endpackage

// ----- design/mti_if.sv -----
// Valid/ready channel interfaces for the masked trilinear interpolator.
// Depends on nothing; parameters follow the top level.
interface mti_query_if #(
    parameter int VALUE_BITS = 24,
    parameter int FRAC_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic        [FRAC_BITS:0]    frac_x;
    logic        [FRAC_BITS:0]    frac_y;
    logic        [FRAC_BITS:0]    frac_z;
    logic signed [VALUE_BITS-1:0] corner_000;
    logic signed [VALUE_BITS-1:0] corner_001;
    logic signed [VALUE_BITS-1:0] corner_010;
    logic signed [VALUE_BITS-1:0] corner_011;
    logic signed [VALUE_BITS-1:0] corner_100;
    logic signed [VALUE_BITS-1:0] corner_101;
    logic signed [VALUE_BITS-1:0] corner_110;
    logic signed [VALUE_BITS-1:0] corner_111;
    logic        [7:0]            blocked_mask;

    modport source (
        output valid, frac_x, frac_y, frac_z,
        output corner_000, corner_001, corner_010, corner_011,
        output corner_100, corner_101, corner_110, corner_111,
        output blocked_mask,
        input  ready
    );

    modport sink (
        input  valid, frac_x, frac_y, frac_z,
        input  corner_000, corner_001, corner_010, corner_011,
        input  corner_100, corner_101, corner_110, corner_111,
        input  blocked_mask,
        output ready
    );
endinterface

interface mti_result_if #(
    parameter int VALUE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] interp_result;

    modport source (output valid, interp_result, input ready);
    modport sink   (input valid, interp_result, output ready);
endinterface

// ----- design/mti_renorm.sv -----
// One renormalization step: drop CORNER if blocked with weight below one, then
// rescale all weights by 1/(1-w) with pipelined radix-2 division. Uses mti_pkg.
module mti_renorm #(
    parameter int VALUE_BITS = 24,
    parameter int FRAC_BITS  = 16,
    parameter int CORNER     = 0
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    adv,
    input  mti_pkg::mti_ctl_t                                       ctl_in,
    input  logic [mti_pkg::NUM_CORNERS-1:0][FRAC_BITS+2:0]          w_in,
    input  logic [mti_pkg::NUM_CORNERS-1:0][VALUE_BITS-1:0]         val_in,
    output mti_pkg::mti_ctl_t                                       ctl_out,
    output logic [mti_pkg::NUM_CORNERS-1:0][FRAC_BITS+2:0]          w_out,
    output logic [mti_pkg::NUM_CORNERS-1:0][VALUE_BITS-1:0]         val_out
);
    import mti_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int WW = F + 3;          // weight width, up to 4.0
    localparam int NW = 2 * F + 3;      // dividend width
    localparam int NS = WW + 1;         // setup stage plus one per quotient bit

    localparam logic [WW-1:0] ONE_W = {2'b00, 1'b1, {F{1'b0}}};
    localparam logic [WW-1:0] WMAX  = {1'b1, {(F+2){1'b0}}};

    mti_ctl_t                                   ctl_reg [NS];
    logic [NUM_CORNERS-1:0][VALUE_BITS-1:0]     val_reg [NS];
    logic [F:0]                                 d_reg   [NS];
    logic [NUM_CORNERS-1:0][NW-1:0]             rem_reg [NS];
    logic [NUM_CORNERS-1:0][WW-1:0]             q_reg   [NS];
    logic [NUM_CORNERS-1:0]                     sat_reg [NS];

    // Setup: pick the divisor, build dividends, flag saturating quotients
    logic [WW-1:0]                  wn;
    logic                           take;
    logic [F:0]                     d_next;
    logic [NW-1:0]                  lim;
    logic [NUM_CORNERS-1:0][NW-1:0] rem_next;
    logic [NUM_CORNERS-1:0]         sat_next;
    logic [WW-1:0]                  wm;

    always_comb
    begin
        wn     = w_in[CORNER];
        take   = ctl_in.mask[CORNER] && (wn < ONE_W);
        // A step that is not taken divides the plain weight by one
        d_next = take ? (ONE_W[F:0] - wn[F:0]) : {{F{1'b0}}, 1'b1};
        lim    = ({{(F+2){1'b0}}, d_next} << (F + 2)) + {{(F+2){1'b0}}, d_next};
        for (int m = 0; m < NUM_CORNERS; m++)
        begin
            wm = (take && (m == CORNER)) ? '0 : w_in[m];
            if (take)
            begin
                rem_next[m] = ({{F{1'b0}}, wm} << F) + {{(F+3){1'b0}}, d_next[F:1]};
            end
            else
            begin
                rem_next[m] = {{F{1'b0}}, wm};
            end
            sat_next[m] = take && (rem_next[m] >= lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_reg[0] <= val_in;
            d_reg[0]   <= d_next;
            rem_reg[0] <= rem_next;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    // Division stages: one quotient bit each, most significant first
    for (genvar s = 1; s < NS; s++)
    begin : g_div
        localparam int            B    = NS - 1 - s;
        localparam logic [WW-1:0] QBIT = WW'(1) << B;

        logic [NW-1:0]                  dsh;
        logic [NUM_CORNERS-1:0][NW-1:0] rem_n;
        logic [NUM_CORNERS-1:0][WW-1:0] q_n;
        logic                           ge;

        always_comb
        begin
            dsh = {{(F+2){1'b0}}, d_reg[s-1]} << B;
            for (int m = 0; m < NUM_CORNERS; m++)
            begin
                ge       = rem_reg[s-1][m] >= dsh;
                rem_n[m] = ge ? (rem_reg[s-1][m] - dsh) : rem_reg[s-1][m];
                q_n[m]   = ge ? (q_reg[s-1][m] | QBIT) : q_reg[s-1][m];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                val_reg[s] <= val_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                rem_reg[s] <= rem_n;
                q_reg[s]   <= q_n;
                sat_reg[s] <= sat_reg[s-1];
            end
        end
    end

    // Clamp saturated quotients at 4.0
    always_comb
    begin
        for (int m = 0; m < NUM_CORNERS; m++)
        begin
            w_out[m] = sat_reg[NS-1][m] ? WMAX : q_reg[NS-1][m];
        end
    end

    assign ctl_out = ctl_reg[NS-1];
    assign val_out = val_reg[NS-1];

endmodule

// ----- design/masked_trilinear_interpolation.sv -----
// Masked trilinear interpolator top level: weights, eight renormalization
// steps, weighted sum. Uses mti_pkg, mti_if and mti_renorm.
//
//  channel  | modport | carries
//  ---------+---------+-------------------------------------------------
//  query    | sink    | frac_x/y/z, corner_000..corner_111, blocked_mask
//  result   | source  | interp_result
//
// Accepts one request per cycle unless a result waits at the output. The
// eight renormalization steps are pipelined long divisions of
// FRAC_BITS+4 stages each. The whole pipeline holds while a result waits
// at the output register; query.ready is low only then. Reset clears only
// the control registers (valid bits and blocked masks).
module masked_trilinear_interpolation #(
    parameter int VALUE_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mti_query_if.sink     query,
    mti_result_if.source  result
);
    import mti_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int V   = VALUE_BITS;
    localparam int WW  = F + 3;
    localparam int PW2 = 2 * F + 2;
    localparam int PW  = WW + 1 + V;
    localparam int SW  = PW + 3;
    localparam int RW  = SW - F;

    localparam logic [F:0]     ONE_F = {1'b1, {F{1'b0}}};
    localparam logic [PW2-1:0] HALF2 = PW2'(1) << (F - 1);
    localparam logic [SW-1:0]  HALFS = SW'(1) << (F - 1);
    localparam logic signed [RW-1:0] VMAX = {{(RW-V+1){1'b0}}, {(V-1){1'b1}}};
    localparam logic signed [RW-1:0] VMIN = {{(RW-V+1){1'b1}}, {(V-1){1'b0}}};

    logic adv;
    logic out_vld_reg;
    logic signed [V-1:0] out_data_reg;

    // Advance everything unless a result is stuck at the output
    assign adv         = !out_vld_reg || result.ready;
    assign query.ready = adv;

    // Stage A: clamp fractions, form complements
    logic [F:0] fin [NUM_AXES];
    mti_ctl_t                          a_ctl_reg;
    logic [F:0]                        a_f_reg [NUM_AXES];
    logic [F:0]                        a_g_reg [NUM_AXES];
    logic [NUM_CORNERS-1:0][V-1:0]     a_val_reg;

    always_comb
    begin
        fin[0] = (query.frac_x > ONE_F) ? ONE_F : query.frac_x;
        fin[1] = (query.frac_y > ONE_F) ? ONE_F : query.frac_y;
        fin[2] = (query.frac_z > ONE_F) ? ONE_F : query.frac_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
        end
        else if (adv)
        begin
            a_ctl_reg.valid <= query.valid;
            a_ctl_reg.mask  <= query.blocked_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < NUM_AXES; n++)
            begin
                a_f_reg[n] <= fin[n];
                a_g_reg[n] <= ONE_F - fin[n];
            end
            a_val_reg[0] <= query.corner_000;
            a_val_reg[1] <= query.corner_001;
            a_val_reg[2] <= query.corner_010;
            a_val_reg[3] <= query.corner_011;
            a_val_reg[4] <= query.corner_100;
            a_val_reg[5] <= query.corner_101;
            a_val_reg[6] <= query.corner_110;
            a_val_reg[7] <= query.corner_111;
        end
    end

    // Stage B: x*y factor products, rounded half up
    logic [PW2-1:0] xy_prod [NUM_XY];
    mti_ctl_t                      b_ctl_reg;
    logic [F:0]                    b_t_reg [NUM_XY];
    logic [F:0]                    b_fz_reg;
    logic [F:0]                    b_gz_reg;
    logic [NUM_CORNERS-1:0][V-1:0] b_val_reg;

    always_comb
    begin
        for (int ij = 0; ij < NUM_XY; ij++)
        begin
            xy_prod[ij] = (((ij & 2) != 0) ? a_f_reg[0] : a_g_reg[0])
                        * (((ij & 1) != 0) ? a_f_reg[1] : a_g_reg[1]) + HALF2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
        end
        else if (adv)
        begin
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ij = 0; ij < NUM_XY; ij++)
            begin
                b_t_reg[ij] <= xy_prod[ij][2*F:F];
            end
            b_fz_reg  <= a_f_reg[2];
            b_gz_reg  <= a_g_reg[2];
            b_val_reg <= a_val_reg;
        end
    end

    // Stage C: multiply in the z factor to get the base weights
    logic [PW2-1:0] z_prod [NUM_CORNERS];
    mti_ctl_t                       c_ctl_reg;
    logic [NUM_CORNERS-1:0][WW-1:0] c_w_reg;
    logic [NUM_CORNERS-1:0][V-1:0]  c_val_reg;

    always_comb
    begin
        for (int n = 0; n < NUM_CORNERS; n++)
        begin
            z_prod[n] = b_t_reg[n >> 1] * (((n & 1) != 0) ? b_fz_reg : b_gz_reg) + HALF2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
        end
        else if (adv)
        begin
            c_ctl_reg <= b_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < NUM_CORNERS; n++)
            begin
                c_w_reg[n] <= {2'b00, z_prod[n][2*F:F]};
            end
            c_val_reg <= b_val_reg;
        end
    end

    // Renormalization chain, corners visited in index order
    mti_ctl_t                       ch_ctl [NUM_CORNERS+1];
    logic [NUM_CORNERS-1:0][WW-1:0] ch_w   [NUM_CORNERS+1];
    logic [NUM_CORNERS-1:0][V-1:0]  ch_val [NUM_CORNERS+1];

    assign ch_ctl[0] = c_ctl_reg;
    assign ch_w[0]   = c_w_reg;
    assign ch_val[0] = c_val_reg;

    for (genvar n = 0; n < NUM_CORNERS; n++)
    begin : g_step
        mti_renorm #(
            .VALUE_BITS (V),
            .FRAC_BITS  (F),
            .CORNER     (n)
        ) u_renorm (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ch_ctl[n]),
            .w_in    (ch_w[n]),
            .val_in  (ch_val[n]),
            .ctl_out (ch_ctl[n+1]),
            .w_out   (ch_w[n+1]),
            .val_out (ch_val[n+1])
        );
    end

    // Stage P: weight times corner value
    logic                 p_vld_reg;
    logic signed [PW-1:0] p_reg [NUM_CORNERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg <= ch_ctl[NUM_CORNERS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < NUM_CORNERS; m++)
            begin
                p_reg[m] <= $signed({1'b0, ch_w[NUM_CORNERS][m]})
                          * $signed(ch_val[NUM_CORNERS][m]);
            end
        end
    end

    // Adder tree, then rounding offset
    logic                   s4_vld_reg;
    logic signed [PW:0]     s4_reg [4];
    logic                   s2_vld_reg;
    logic signed [PW+1:0]   s2_reg [2];
    logic                   acc_vld_reg;
    logic signed [SW-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            acc_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg  <= p_vld_reg;
            s2_vld_reg  <= s4_vld_reg;
            acc_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s4_reg[k] <= {p_reg[2*k][PW-1], p_reg[2*k]}
                           + {p_reg[2*k+1][PW-1], p_reg[2*k+1]};
            end
            for (int k = 0; k < 2; k++)
            begin
                s2_reg[k] <= {s4_reg[2*k][PW], s4_reg[2*k]}
                           + {s4_reg[2*k+1][PW], s4_reg[2*k+1]};
            end
            acc_reg <= {s2_reg[0][PW+1], s2_reg[0]} + {s2_reg[1][PW+1], s2_reg[1]}
                     + $signed(HALFS);
        end
    end

    // Output: drop fraction bits and saturate
    logic signed [RW-1:0] shifted;
    logic signed [V-1:0]  sat_val;

    always_comb
    begin
        shifted = acc_reg[SW-1:F];
        if (shifted > VMAX)
        begin
            sat_val = VMAX[V-1:0];
        end
        else if (shifted < VMIN)
        begin
            sat_val = VMIN[V-1:0];
        end
        else
        begin
            sat_val = shifted[V-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= acc_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= sat_val;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.interp_result = out_data_reg;

endmodule

// ----- design/mti_checker.sv -----
// Port-level checks for the masked trilinear interpolator, bound to the top.
// Depends on masked_trilinear_interpolation.
module mti_checker #(
    parameter int VALUE_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  q_ready,
    input logic                  r_valid,
    input logic                  r_ready,
    input logic [VALUE_BITS-1:0] r_data
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_data))
        else $error("result changed while stalled");

    // Take requests whenever the output register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> q_ready)
        else $error("request refused with empty output");

    // Stall the input while a result waits
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |-> !q_ready)
        else $error("request taken while pipeline holds");

endmodule

bind masked_trilinear_interpolation mti_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_mti_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_data  (result.interp_result)
);
